/* design/mlv_pkg.sv */
// shared types, constants and microprogram for the mecanum velocity step
`default_nettype none
package mlv_pkg;

  localparam int FRAC_BITS = 16;

  // fixed-point constants
  localparam longint PI_Q =
    longint'((64'd13493037705 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam longint TWO_PI_Q = 2 * PI_Q;
  localparam longint CAP_LIN = longint'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam longint CAP_ANG = longint'(((64'd7 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_TOP = 64'sd2147483648;

  // field and datapath widths
  localparam int ERR_W   = 24;
  localparam int YAW_W   = 20;
  localparam int OUT_W   = 14;
  localparam int GAIN_W  = 24;
  localparam int STEP_W  = 17;
  localparam int LIM_W   = 22;
  localparam int RAD_W   = 17;
  localparam int ARM_W   = 19;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int LAST_W  = 16;
  localparam int V_W     = 33;
  localparam int T_W     = 36;
  localparam int WS_W    = 37;
  localparam int WH_W    = LIM_W + 1;
  localparam int S_W     = WH_W + 2;
  localparam int MA_W    = V_W;
  localparam int MB_W    = GAIN_W + 1;
  localparam int P_W     = MA_W + MB_W;
  localparam int DIV_NUM_W = WS_W + FRAC_BITS;
  localparam int DIV_DEN_W = ARM_W + 2;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam int PC_W    = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_YAW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ANG   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SUM   = 3'd7;

  // axis selectors
  localparam logic [1:0] AX_X   = 2'd0;
  localparam logic [1:0] AX_Y   = 2'd1;
  localparam logic [1:0] AX_YAW = 2'd2;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_WRAP,
    OP_MUL_GAIN,
    OP_GAIN_ROUND,
    OP_SLEW,
    OP_MUL_ARM,
    OP_T_ROUND,
    OP_WSUM,
    OP_DIV_WHEEL,
    OP_WHEEL_CLIP,
    OP_SUM,
    OP_MUL_R,
    OP_LIN_OUT,
    OP_DIV_ANG,
    OP_ANG_OUT,
    OP_COMMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_DIV_BUSY,
    C_WHEEL_MORE,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       sel;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  function automatic ucode_t uc_word(input op_t op, input logic [1:0] sel,
                                     input cond_t cond, input int tgt);
    ucode_t u;
    u.op = op;
    u.sel = sel;
    u.cond = cond;
    u.target = PC_W'(tgt);
    return u;
  endfunction

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t u;
    case (pc)
      5'd0:  u = uc_word(OP_LOAD,       AX_X,   C_NO_INPUT,   0);
      5'd1:  u = uc_word(OP_WRAP,       AX_X,   C_NEXT,       0);
      5'd2:  u = uc_word(OP_MUL_GAIN,   AX_X,   C_NEXT,       0);
      5'd3:  u = uc_word(OP_GAIN_ROUND, AX_X,   C_NEXT,       0);
      5'd4:  u = uc_word(OP_SLEW,       AX_X,   C_NEXT,       0);
      5'd5:  u = uc_word(OP_MUL_GAIN,   AX_Y,   C_NEXT,       0);
      5'd6:  u = uc_word(OP_GAIN_ROUND, AX_Y,   C_NEXT,       0);
      5'd7:  u = uc_word(OP_SLEW,       AX_Y,   C_NEXT,       0);
      5'd8:  u = uc_word(OP_MUL_GAIN,   AX_YAW, C_NEXT,       0);
      5'd9:  u = uc_word(OP_GAIN_ROUND, AX_YAW, C_NEXT,       0);
      5'd10: u = uc_word(OP_SLEW,       AX_YAW, C_NEXT,       0);
      5'd11: u = uc_word(OP_MUL_ARM,    AX_YAW, C_NEXT,       0);
      5'd12: u = uc_word(OP_T_ROUND,    AX_YAW, C_NEXT,       0);
      5'd13: u = uc_word(OP_WSUM,       AX_X,   C_NEXT,       0);
      5'd14: u = uc_word(OP_DIV_WHEEL,  AX_X,   C_NEXT,       0);
      5'd15: u = uc_word(OP_NOP,        AX_X,   C_DIV_BUSY,   15);
      5'd16: u = uc_word(OP_WHEEL_CLIP, AX_X,   C_WHEEL_MORE, 13);
      5'd17: u = uc_word(OP_SUM,        AX_X,   C_NEXT,       0);
      5'd18: u = uc_word(OP_MUL_R,      AX_X,   C_NEXT,       0);
      5'd19: u = uc_word(OP_LIN_OUT,    AX_X,   C_NEXT,       0);
      5'd20: u = uc_word(OP_SUM,        AX_Y,   C_NEXT,       0);
      5'd21: u = uc_word(OP_MUL_R,      AX_Y,   C_NEXT,       0);
      5'd22: u = uc_word(OP_LIN_OUT,    AX_Y,   C_NEXT,       0);
      5'd23: u = uc_word(OP_SUM,        AX_YAW, C_NEXT,       0);
      5'd24: u = uc_word(OP_MUL_R,      AX_YAW, C_NEXT,       0);
      5'd25: u = uc_word(OP_DIV_ANG,    AX_YAW, C_NEXT,       0);
      5'd26: u = uc_word(OP_NOP,        AX_YAW, C_DIV_BUSY,   26);
      5'd27: u = uc_word(OP_ANG_OUT,    AX_YAW, C_NEXT,       0);
      5'd28: u = uc_word(OP_NOP,        AX_X,   C_OUT_FULL,   28);
      5'd29: u = uc_word(OP_COMMIT,     AX_X,   C_ALWAYS,     0);
      default: u = uc_word(OP_NOP,      AX_X,   C_ALWAYS,     0);
    endcase
    return u;
  endfunction

  // shift right, rounding to nearest with ties away from zero
  function automatic logic signed [P_W-1:0] round_shr(input logic signed [P_W-1:0] x,
                                                      input int sh);
    logic signed [P_W-1:0] half;
    half = P_W'(1) <<< (sh - 1);
    return (x + (x < 0 ? half - P_W'(1) : half)) >>> sh;
  endfunction

endpackage
`default_nettype wire

/* design/mlv_div.sv */
// bit-serial restoring divider for unsigned magnitudes
`default_nettype none
module mlv_div
  import mlv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire div_req_t             req,
  output logic                      busy,
  output logic [DIV_NUM_W-1:0]      quo
);

  logic                   busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0]   quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0]   rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0]   den_r, den_nxt;
  logic [DIV_DEN_W:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[DIV_NUM_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W - 1);
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DIV_DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DEN_W-1:0];
        quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

/* design/mecanum_lqr_velocity_step.sv */
// mecanum state-feedback velocity step: microcoded datapath and control store
//
//   channel | ports                      | direction | contents
//   --------+----------------------------+-----------+-----------------------------
//   in      | in_tvalid/in_tready/in_tdata   | in   | error_x, error_y, error_yaw
//   out     | out_tvalid/out_tready/out_tdata| out  | vel_x, vel_y, yaw_rate
//   cfg     | cfg_wr_en/cfg_index/cfg_wdata  | in   | eight gain, limit and geometry registers
//
// a request runs from the load step back to the load step through the control steps plus
// five divider waits (the divider's quotient-bit steps and one idle check each, for four
// wheel speeds and the yaw rate) on one shared bit-serial divider.
// in_tready is high only on the load step; a finished result waits in the output register
// while the next request is already being worked on, and the sequencer holds before commit
// until that register is free.
// synchronous reset restores register defaults and clears the stored command.
`default_nettype none
module mecanum_lqr_velocity_step
  import mlv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [71:0]          in_tdata,   // error_x, error_y, error_yaw, zero pad
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [47:0]               out_tdata,  // vel_x, vel_y, yaw_rate, zero pad
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic signed [YAW_W:0] PI_Y     = (YAW_W + 1)'(PI_Q);
  localparam logic signed [YAW_W:0] TWO_PI_Y = (YAW_W + 1)'(TWO_PI_Q);
  localparam int OUT_BITS = 3 * OUT_W;

  // configuration registers
  logic [GAIN_W-1:0] gain_x_r, gain_y_r, gain_yaw_r;
  logic [STEP_W-1:0] step_lin_r, step_ang_r;
  logic [LIM_W-1:0]  wheel_lim_r;
  logic [RAD_W-1:0]  radius_r;
  logic [ARM_W-1:0]  half_sum_r;
  logic [RAD_W-1:0]  r_eff;
  logic [ARM_W-1:0]  arm_eff;

  // sequencer
  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          uc;
  logic            take_jump;
  logic [1:0]      wcnt_r, wcnt_nxt;

  // datapath
  logic signed [ERR_W-1:0]  ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [YAW_W-1:0]  yaw_r, yaw_nxt;
  logic signed [V_W-1:0]    v_r [3];
  logic signed [V_W-1:0]    v_nxt [3];
  logic signed [LAST_W-1:0] last_r [3];
  logic signed [T_W-1:0]    t_r, t_nxt;
  logic signed [WS_W-1:0]   ws_r, ws_nxt;
  logic signed [WH_W-1:0]   w_r [4];
  logic signed [WH_W-1:0]   w_nxt [4];
  logic signed [S_W-1:0]    s_r, s_nxt;
  logic signed [P_W-1:0]    prod_r, prod_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     out_valid_r;
  logic [OUT_BITS-1:0]      out_data_r;

  div_req_t               div_req;
  logic                   div_busy;
  logic [DIV_NUM_W-1:0]   div_quo;

  // scratch values
  logic signed [YAW_W:0]    yw;
  logic signed [P_W-1:0]    rnd, clip_lo, clip_hi;
  logic signed [V_W:0]      sl_prev, sl_want, sl_step, sl_d;
  logic signed [WS_W-1:0]   tv_x, tv_y, tv_t;
  logic signed [S_W-1:0]    sw [4];
  logic signed [DIV_NUM_W:0] dx, dh;
  logic signed [P_W-1:0]    ph;
  logic [LIM_W-1:0]         wm;
  logic signed [V_W-1:0]    am;

  assign r_eff   = (radius_r == '0) ? RAD_W'(1) : radius_r;
  assign arm_eff = (half_sum_r == '0) ? ARM_W'(1) : half_sum_r;
  assign uc      = ucode_rom(pc_r);

  assign in_tready  = (uc.op == OP_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(48 - OUT_BITS){1'b0}}, out_data_r};

  always_comb begin
    case (uc.cond)
      C_NEXT:       take_jump = 1'b0;
      C_ALWAYS:     take_jump = 1'b1;
      C_NO_INPUT:   take_jump = !in_tvalid;
      C_DIV_BUSY:   take_jump = div_busy;
      C_WHEEL_MORE: take_jump = (wcnt_r != 2'd3);
      C_OUT_FULL:   take_jump = out_valid_r && !out_tready;
      default:      take_jump = 1'b0;
    endcase
    pc_nxt = take_jump ? uc.target : pc_r + PC_W'(1);
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uc.op)
      OP_MUL_GAIN: begin
        case (uc.sel)
          AX_X: begin
            mul_a = MA_W'(ex_r);
            mul_b = MB_W'(signed'({1'b0, gain_x_r}));
          end
          AX_Y: begin
            mul_a = MA_W'(ey_r);
            mul_b = MB_W'(signed'({1'b0, gain_y_r}));
          end
          default: begin
            mul_a = -MA_W'(yaw_r);
            mul_b = MB_W'(signed'({1'b0, gain_yaw_r}));
          end
        endcase
      end
      OP_MUL_ARM: begin
        mul_a = v_r[AX_YAW];
        mul_b = MB_W'(signed'({1'b0, arm_eff}));
      end
      OP_MUL_R: begin
        mul_a = MA_W'(s_r);
        mul_b = MB_W'(signed'({1'b0, r_eff}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    ex_nxt   = ex_r;
    ey_nxt   = ey_r;
    yaw_nxt  = yaw_r;
    v_nxt    = v_r;
    t_nxt    = t_r;
    ws_nxt   = ws_r;
    w_nxt    = w_r;
    s_nxt    = s_r;
    prod_nxt = prod_r;
    neg_nxt  = neg_r;
    wcnt_nxt = wcnt_r;
    div_req  = '0;

    yw      = (YAW_W + 1)'(yaw_r);
    rnd     = round_shr(prod_r, FRAC_BITS);
    clip_lo = -P_W'(I32_TOP);
    clip_hi = P_W'(I32_MAX);
    sl_prev = (V_W + 1)'(last_r[uc.sel]);
    sl_want = (V_W + 1)'(v_r[uc.sel]);
    sl_step = (uc.sel == AX_YAW) ? (V_W + 1)'(signed'({1'b0, step_ang_r}))
                                 : (V_W + 1)'(signed'({1'b0, step_lin_r}));
    sl_d    = sl_want - sl_prev;
    tv_x    = WS_W'(v_r[AX_X]);
    tv_y    = WS_W'(v_r[AX_Y]);
    tv_t    = WS_W'(t_r);
    for (int i = 0; i < 4; i++) begin
      sw[i] = S_W'(w_r[i]);
    end
    dx = (DIV_NUM_W + 1)'(ws_r) <<< FRAC_BITS;
    dh = (DIV_NUM_W + 1)'(signed'({1'b0, r_eff[RAD_W-1:1]}));
    ph = P_W'(signed'({1'b0, arm_eff, 1'b0}));
    wm = (div_quo > DIV_NUM_W'(wheel_lim_r)) ? wheel_lim_r : div_quo[LIM_W-1:0];
    am = (div_quo > DIV_NUM_W'(CAP_ANG)) ? V_W'(CAP_ANG) : V_W'(signed'({1'b0, div_quo[12:0]}));

    case (uc.op)
      OP_LOAD: begin
        if (in_tvalid) begin
          ex_nxt   = in_tdata[ERR_W-1:0];
          ey_nxt   = in_tdata[2*ERR_W-1:ERR_W];
          yaw_nxt  = in_tdata[2*ERR_W+YAW_W-1:2*ERR_W];
          wcnt_nxt = 2'd0;
        end
      end
      OP_WRAP: begin
        if (yw > PI_Y) begin
          yaw_nxt = YAW_W'(yw - TWO_PI_Y);
        end else if (yw < -PI_Y) begin
          yaw_nxt = YAW_W'(yw + TWO_PI_Y);
        end
      end
      OP_MUL_GAIN, OP_MUL_ARM, OP_MUL_R: begin
        prod_nxt = P_W'(mul_a * mul_b);
      end
      OP_GAIN_ROUND: begin
        if (uc.sel == AX_YAW) begin
          clip_lo = -P_W'(I32_MAX);
          clip_hi = P_W'(I32_TOP);
        end
        if (rnd < clip_lo) begin
          v_nxt[uc.sel] = V_W'(clip_lo);
        end else if (rnd > clip_hi) begin
          v_nxt[uc.sel] = V_W'(clip_hi);
        end else begin
          v_nxt[uc.sel] = V_W'(rnd);
        end
      end
      OP_SLEW: begin
        if (sl_d > sl_step) begin
          v_nxt[uc.sel] = V_W'(sl_prev + sl_step);
        end else if (sl_d < -sl_step) begin
          v_nxt[uc.sel] = V_W'(sl_prev - sl_step);
        end
      end
      OP_T_ROUND: begin
        t_nxt = T_W'(rnd);
      end
      OP_WSUM: begin
        case (wcnt_r)
          2'd0:    ws_nxt = tv_x - tv_y - tv_t;
          2'd1:    ws_nxt = tv_x + tv_y + tv_t;
          2'd2:    ws_nxt = tv_x + tv_y - tv_t;
          default: ws_nxt = tv_x - tv_y + tv_t;
        endcase
      end
      OP_DIV_WHEEL: begin
        neg_nxt       = ws_r < 0;
        div_req.start = 1'b1;
        div_req.num   = (ws_r < 0) ? DIV_NUM_W'(dh - dx) : DIV_NUM_W'(dx + dh);
        div_req.den   = DIV_DEN_W'(r_eff);
      end
      OP_WHEEL_CLIP: begin
        w_nxt[wcnt_r] = neg_r ? -WH_W'(signed'({1'b0, wm})) : WH_W'(signed'({1'b0, wm}));
        wcnt_nxt      = wcnt_r + 2'd1;
      end
      OP_SUM: begin
        case (uc.sel)
          AX_X:    s_nxt = sw[0] + sw[1] + sw[2] + sw[3];
          AX_Y:    s_nxt = sw[1] + sw[2] - sw[0] - sw[3];
          default: s_nxt = sw[1] + sw[3] - sw[0] - sw[2];
        endcase
      end
      OP_LIN_OUT: begin
        rnd = round_shr(prod_r, FRAC_BITS + 2);
        if (rnd > P_W'(CAP_LIN)) begin
          v_nxt[uc.sel] = V_W'(CAP_LIN);
        end else if (rnd < -P_W'(CAP_LIN)) begin
          v_nxt[uc.sel] = -V_W'(CAP_LIN);
        end else begin
          v_nxt[uc.sel] = V_W'(rnd);
        end
      end
      OP_DIV_ANG: begin
        neg_nxt       = prod_r < 0;
        div_req.start = 1'b1;
        div_req.num   = (prod_r < 0) ? DIV_NUM_W'(ph - prod_r) : DIV_NUM_W'(prod_r + ph);
        div_req.den   = {arm_eff, 2'b00};
      end
      OP_ANG_OUT: begin
        v_nxt[AX_YAW] = neg_r ? -am : am;
      end
      default: begin
      end
    endcase
  end

  mlv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      gain_x_r    <= GAIN_W'(142069);
      gain_y_r    <= GAIN_W'(142069);
      gain_yaw_r  <= GAIN_W'(104107);
      step_lin_r  <= STEP_W'(655);
      step_ang_r  <= STEP_W'(655);
      wheel_lim_r <= LIM_W'(131072);
      radius_r    <= RAD_W'(3277);
      half_sum_r  <= ARM_W'(30540);
      for (int i = 0; i < 3; i++) begin
        last_r[i] <= '0;
      end
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_GAIN_X:    gain_x_r    <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_Y:    gain_y_r    <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_YAW:  gain_yaw_r  <= cfg_wdata[GAIN_W-1:0];
          REG_STEP_LIN:  step_lin_r  <= cfg_wdata[STEP_W-1:0];
          REG_STEP_ANG:  step_ang_r  <= cfg_wdata[STEP_W-1:0];
          REG_WHEEL_LIM: wheel_lim_r <= cfg_wdata[LIM_W-1:0];
          REG_RADIUS:    radius_r    <= cfg_wdata[RAD_W-1:0];
          REG_HALF_SUM:  half_sum_r  <= cfg_wdata[ARM_W-1:0];
          default: begin
          end
        endcase
      end
      if (uc.op == OP_COMMIT) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          last_r[i] <= v_r[i][LAST_W-1:0];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    ex_r   <= ex_nxt;
    ey_r   <= ey_nxt;
    yaw_r  <= yaw_nxt;
    v_r    <= v_nxt;
    t_r    <= t_nxt;
    ws_r   <= ws_nxt;
    w_r    <= w_nxt;
    s_r    <= s_nxt;
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
    wcnt_r <= wcnt_nxt;
    if (uc.op == OP_COMMIT) begin
      out_data_r <= {v_r[AX_YAW][OUT_W-1:0], v_r[AX_Y][OUT_W-1:0], v_r[AX_X][OUT_W-1:0]};
    end
  end

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_busy)
    else $error("request taken while the divider is still running");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (uc.op == OP_COMMIT) |-> (!out_valid_r || out_tready))
    else $error("result overwrites one that was not taken");

  a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
    (uc.op == OP_DIV_WHEEL || uc.op == OP_DIV_ANG) |=> div_busy)
    else $error("division did not start");

  a_yaw_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (last_r[AX_YAW] <= LAST_W'(CAP_ANG)) && (last_r[AX_YAW] >= -LAST_W'(CAP_ANG)))
    else $error("stored yaw rate beyond its cap");

endmodule
`default_nettype wire

/* verif/tb.sv */
// self-checking testbench for mecanum_lqr_velocity_step: random pose errors, register sweeps
`default_nettype none
module tb;
  import mlv_pkg::*;

  typedef struct packed {
    logic signed [YAW_W-1:0] yaw;
    logic signed [ERR_W-1:0] ey;
    logic signed [ERR_W-1:0] ex;
  } pose_err_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] wz;
    logic signed [OUT_W-1:0] vy;
    logic signed [OUT_W-1:0] vx;
  } vel_cmd_t;

  localparam longint ONE_FX = 64'sd1 << FRAC_BITS;
  localparam longint PI_FX =
    (64'd13493037705 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam longint VLIN_CAP = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam longint VANG_CAP = ((64'd7 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam longint I32_HI = 64'sd2147483647;
  localparam longint I32_LO = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;  // error_x, error_y, error_yaw, zero pad
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;      // vel_x, vel_y, yaw_rate, zero pad
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  mecanum_lqr_velocity_step DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [CFG_IDX_W-1:0] reg_idx[8] = '{REG_GAIN_X, REG_GAIN_Y, REG_GAIN_YAW, REG_STEP_LIN,
                                        REG_STEP_ANG, REG_WHEEL_LIM, REG_RADIUS, REG_HALF_SUM};
  int     reg_w[8]   = '{24, 24, 24, 17, 17, 22, 17, 19};
  longint reg_rst[8] = '{142069, 142069, 104107, 655, 655, 131072, 3277, 30540};
  longint reg_lo[8]  = '{0, 0, 0, 0, 0, 0, 655, 655};
  longint reg_hi[8]  = '{16777215, 16777215, 16777215, 65536, 65536, 2097152, 65536, 262144};

  longint regs_now[8];
  longint next_regs[8];
  longint last_vx = 0;
  longint last_vy = 0;
  longint last_wz = 0;

  pose_err_t pending_errs[$];
  vel_cmd_t  vel_expected[$];
  int mism = 0;
  logic in_taken = 1'b0;
  logic hold_armed = 1'b0;

  function automatic longint rdiv(input longint num, input longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint slew(input longint want, input longint prev, input longint step);
    if (want - prev > step) return prev + step;
    if (want - prev < -step) return prev - step;
    return want;
  endfunction

  function automatic longint gain_term(input longint g, input longint e);
    return clamp(rdiv(g * e, ONE_FX), I32_LO, I32_HI);
  endfunction

  function automatic vel_cmd_t predict_cmd(input pose_err_t e);
    longint ex, ey, yaw, rad, arm, lim, vx, vy, wz, t;
    longint w[4];
    vel_cmd_t r;
    ex = $signed(e.ex);
    ey = $signed(e.ey);
    yaw = $signed(e.yaw);
    rad = regs_now[REG_RADIUS] != 0 ? regs_now[REG_RADIUS] : 1;
    arm = regs_now[REG_HALF_SUM] != 0 ? regs_now[REG_HALF_SUM] : 1;
    lim = regs_now[REG_WHEEL_LIM];
    while (yaw > PI_FX) yaw -= 2 * PI_FX;
    while (yaw < -PI_FX) yaw += 2 * PI_FX;
    vx = slew(gain_term(regs_now[REG_GAIN_X], ex), last_vx, regs_now[REG_STEP_LIN]);
    vy = slew(gain_term(regs_now[REG_GAIN_Y], ey), last_vy, regs_now[REG_STEP_LIN]);
    wz = slew(-gain_term(regs_now[REG_GAIN_YAW], yaw), last_wz, regs_now[REG_STEP_ANG]);
    t = rdiv(arm * wz, ONE_FX);
    w[0] = vx - vy - t;
    w[1] = vx + vy + t;
    w[2] = vx + vy - t;
    w[3] = vx - vy + t;
    for (int i = 0; i < 4; i++)
      w[i] = clamp(rdiv(w[i] * ONE_FX, rad), -lim, lim);
    vx = clamp(rdiv((w[0] + w[1] + w[2] + w[3]) * rad, 4 * ONE_FX), -VLIN_CAP, VLIN_CAP);
    vy = clamp(rdiv((-w[0] + w[1] + w[2] - w[3]) * rad, 4 * ONE_FX), -VLIN_CAP, VLIN_CAP);
    wz = clamp(rdiv((-w[0] + w[1] - w[2] + w[3]) * rad, 4 * arm), -VANG_CAP, VANG_CAP);
    last_vx = vx;
    last_vy = vy;
    last_wz = wz;
    r.vx = vx[OUT_W-1:0];
    r.vy = vy[OUT_W-1:0];
    r.wz = wz[OUT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      mism++;
    end
  endtask

  // request and result monitor
  always @(posedge clk) begin
    vel_cmd_t got, want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      vel_expected.push_back(predict_cmd(pose_err_t'(in_tdata[67:0])));
    if (rst_n && out_tvalid && out_tready) begin
      got = vel_cmd_t'(out_tdata[41:0]);
      if (vel_expected.size() == 0) begin
        $error("result with no request pending: %h", out_tdata);
        mism++;
      end else begin
        want = vel_expected.pop_front();
        check_field("vel_x", want.vx, got.vx);
        check_field("vel_y", want.vy, got.vy);
        check_field("yaw_rate", want.wz, got.wz);
      end
    end
  end

  // request driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_errs.size() > 0) begin
        in_tdata <= {4'b0, pending_errs.pop_front()};
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 7);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1, 2: gap_left = $urandom_range(1, 20);
            default: gap_left = $urandom_range(1, 400);
          endcase
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: ready and stall runs, plus one long hold-off
  int hold_left = 0;
  logic hold_taken = 1'b0;
  int rdy_left = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_armed && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = 2500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (rdy_left > 0) begin
      rdy_left--;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      rdy_left = $urandom_range(0, 40);
      case ($urandom_range(0, 3))
        0: stall_left = 0;
        1: stall_left = $urandom_range(1, 8);
        2: stall_left = $urandom_range(1, 60);
        default: stall_left = $urandom_range(1, 400);
      endcase
      out_tready <= 1'b1;
    end
  end

  task automatic push_err(input longint ex, input longint ey, input longint yaw);
    pose_err_t p;
    p.ex = ex[ERR_W-1:0];
    p.ey = ey[ERR_W-1:0];
    p.yaw = yaw[YAW_W-1:0];
    pending_errs.push_back(p);
  endtask

  function automatic longint corner_val(input int w);
    case ($urandom_range(0, 4))
      0: return -(64'sd1 <<< (w - 1));
      1: return (64'sd1 <<< (w - 1)) - 1;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic longint srand(input int n);
    return longint'($urandom_range(0, 2 * n)) - n;
  endfunction

  task automatic push_random();
    longint yaw;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: push_err($urandom(), $urandom(), $urandom());
      4, 5, 6: push_err(srand(1 << 17), srand(1 << 17), srand(411775));
      7: push_err(corner_val(ERR_W), corner_val(ERR_W), corner_val(YAW_W));
      8: begin
        yaw = ($urandom_range(0, 1) ? PI_FX : 2 * PI_FX) + srand(2);
        push_err(srand(1 << 12), srand(1 << 12), $urandom_range(0, 1) ? yaw : -yaw);
      end
      default: push_err(0, 0, 0);
    endcase
  endtask

  task automatic drain();
    while (pending_errs.size() != 0 || in_tvalid || vel_expected.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_wdata <= next_regs[i][CFG_W-1:0];
      regs_now[reg_idx[i]] = next_regs[i] & ((64'd1 << reg_w[i]) - 1);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic longint rand_reg(input int i);
    case ($urandom_range(0, 7))
      0: return reg_rst[i];
      1: return reg_lo[i];
      2: return reg_hi[i];
      3: return 0;
      4, 5: return $urandom_range(reg_lo[i], reg_hi[i]);
      default: return $urandom() & 32'hFFFFFF;
    endcase
  endfunction

  task automatic run_phase(input int n);
    write_regs();
    repeat (n) push_random();
    drain();
  endtask

  initial begin
    foreach (regs_now[i]) regs_now[i] = reg_rst[i];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_err(0, 0, 0);
    push_err(8388607, -8388608, 0);
    push_err(-8388608, 8388607, 0);
    push_err(0, 0, PI_FX);
    push_err(0, 0, -PI_FX);
    push_err(0, 0, PI_FX + 1);
    push_err(0, 0, -PI_FX - 1);
    push_err(0, 0, 411775);
    push_err(0, 0, -411775);
    push_err(0, 0, 524287);
    push_err(0, 0, -524288);
    push_err(-1, -1, -1);
    push_err(1, 1, 1);
    // ramp into the velocity caps under the slew limit
    repeat (8) push_err(1 << 20, -(1 << 20), 150000);
    repeat (2) push_err(-(1 << 20), 1 << 20, -150000);
    drain();

    foreach (next_regs[i]) next_regs[i] = (64'd1 << reg_w[i]) - 1;
    run_phase(60);
    foreach (next_regs[i]) next_regs[i] = 0;
    run_phase(60);
    foreach (next_regs[i]) next_regs[i] = reg_hi[i];
    run_phase(60);
    foreach (next_regs[i]) next_regs[i] = reg_lo[i];
    run_phase(60);

    for (int ph = 0; ph < 10; ph++) begin
      foreach (next_regs[i]) next_regs[i] = rand_reg(i);
      if (ph == 3) hold_armed = 1'b1;
      run_phase(125);
    end

    repeat (400) @(posedge clk);
    if (mism == 0 && vel_expected.size() == 0)
      $display("mecanum_lqr_velocity_step: match");
    else
      $display("mecanum_lqr_velocity_step: mismatch");
    $finish;
  end

  initial begin
    #120000000;
    $display("mecanum_lqr_velocity_step: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
